[design/tskl_pkg.sv]
// Package for the SQL keyword locator: status codes, header constants, keyword
// patterns and register indexes. It depends on nothing.
`timescale 1ns / 1ps

package tskl_pkg;

  localparam int POSITION_WIDTH_DEFAULT = 16;
  localparam int HEADER_BYTES           = 8;
  localparam int SCAN_LAG               = 12;
  localparam logic [7:0] SQL_BATCH_TYPE = 8'h01;

  localparam int SCAN_LIMIT_WIDTH = 12;
  localparam int QUERY_CAP_WIDTH  = 16;
  localparam int LENGTH_WIDTH     = 16;
  localparam int OFFSET_WIDTH     = 12;
  localparam int CFG_DATA_WIDTH   = 16;
  localparam int STATUS_WIDTH     = 3;
  localparam int OUT_DATA_WIDTH   = 32;

  localparam logic [SCAN_LIMIT_WIDTH-1:0] SCAN_LIMIT_RESET = 12'd200;
  localparam logic [QUERY_CAP_WIDTH-1:0]  QUERY_CAP_RESET  = 16'd512;

  typedef enum logic [0:0] {
    REG_SCAN_LIMIT = 1'b0,
    REG_QUERY_CAP  = 1'b1
  } reg_index_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_FOUND      = 3'd0,
    ST_SHORT      = 3'd1,
    ST_NOT_BATCH  = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_NO_KEYWORD = 3'd4
  } status_t;

  localparam logic [39:0] KW_SELEC = 40'h53454C4543;
  localparam logic [39:0] KW_INSER = 40'h494E534552;
  localparam logic [39:0] KW_UPDAT = 40'h5550444154;
  localparam logic [39:0] KW_DELET = 40'h44454C4554;
  localparam logic [31:0] KW_EXEC  = 32'h45584543;

  typedef struct packed {
    logic [LENGTH_WIDTH-1:0] query_length;
    logic [OFFSET_WIDTH-1:0] query_offset;
    status_t                 status;
  } result_t;

endpackage

[design/tskl_keyword_match.sv]
// Keyword comparator for the SQL keyword locator: tests a five-byte window for
// SELEC, INSER, UPDAT, DELET, or EXEC in its four oldest bytes. Uses tskl_pkg.
`timescale 1ns / 1ps

module tskl_keyword_match (
  input  logic [39:0] window,
  output logic        hit
);

  always_comb begin
    hit = (window == tskl_pkg::KW_SELEC) ||
          (window == tskl_pkg::KW_INSER) ||
          (window == tskl_pkg::KW_UPDAT) ||
          (window == tskl_pkg::KW_DELET) ||
          (window[39:8] == tskl_pkg::KW_EXEC);
  end

endmodule

[design/tds_sql_keyword_locator_top.sv]
// Top level of the SQL keyword locator: header checks, byte window, match
// tracking and a two-entry result buffer. Uses tskl_pkg and tskl_keyword_match.
`timescale 1ns / 1ps

// The block takes one packet byte per cycle while s_tready is high and needs no
// gaps. It registers one result transaction for the byte marked tlast. The
// keyword test and header checks are combinational between the input
// transaction and the result register. A two-entry result buffer lets input
// continue while a result waits; s_tready drops only when both entries hold
// results that the downstream side has not taken. Configuration writes take
// effect at the next clock edge and must be made while the block is idle.
module tds_sql_keyword_locator_top #(
  parameter int POSITION_WIDTH = tskl_pkg::POSITION_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // [7:0] data_byte
  input  logic                                s_tlast,  // last_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] status, [14:3] query_offset, [30:15] query_length, [31] zero
  output logic [tskl_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [tskl_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

  localparam int PW   = POSITION_WIDTH;
  localparam int CMPW = (PW > tskl_pkg::LENGTH_WIDTH) ? PW : tskl_pkg::LENGTH_WIDTH;
  localparam int SW   = (PW > tskl_pkg::SCAN_LIMIT_WIDTH) ? PW : tskl_pkg::SCAN_LIMIT_WIDTH;

  logic [tskl_pkg::SCAN_LIMIT_WIDTH-1:0] scan_limit;
  logic [tskl_pkg::QUERY_CAP_WIDTH-1:0]  query_cap;

  logic [PW-1:0]                     byte_position;
  logic [39:0]                       byte_window;
  logic [7:0]                        type_byte;
  logic [tskl_pkg::LENGTH_WIDTH-1:0] declared_length;
  logic                              match_seen;
  logic [tskl_pkg::OFFSET_WIDTH-1:0] match_offset;

  logic [PW-1:0]                     byte_position_next;
  logic [39:0]                       byte_window_next;
  logic [7:0]                        type_byte_next;
  logic [tskl_pkg::LENGTH_WIDTH-1:0] declared_length_next;
  logic                              match_seen_next;
  logic [tskl_pkg::OFFSET_WIDTH-1:0] match_offset_next;

  logic                      in_fire;
  logic                      res_fire;
  logic                      saturated;
  logic                      keyword_hit;
  logic [PW-1:0]             start;
  logic [SW-1:0]             start_ext;
  logic [tskl_pkg::LENGTH_WIDTH-1:0] qlen;
  tskl_pkg::result_t         result;

  logic              out_valid;
  tskl_pkg::result_t out_data;
  logic              skid_valid;
  tskl_pkg::result_t skid_data;

  assign byte_window_next = {byte_window[31:0], s_tdata};

  tskl_keyword_match u_match (
    .window (byte_window_next),
    .hit    (keyword_hit)
  );

  assign in_fire   = s_tvalid && s_tready;
  assign res_fire  = in_fire && s_tlast;
  assign saturated = (byte_position == {PW{1'b1}});
  assign start     = byte_position - PW'(tskl_pkg::SCAN_LAG);
  assign start_ext = SW'(start);

  always_comb begin
    byte_position_next   = byte_position;
    type_byte_next       = type_byte;
    declared_length_next = declared_length;
    match_seen_next      = match_seen;
    match_offset_next    = match_offset;
    if (!saturated) begin
      byte_position_next = byte_position + PW'(1);
      if (byte_position == PW'(0)) begin
        type_byte_next = s_tdata;
      end else if (byte_position == PW'(2)) begin
        declared_length_next = {s_tdata, declared_length[7:0]};
      end else if (byte_position == PW'(3)) begin
        declared_length_next = {declared_length[15:8], s_tdata};
      end else if (byte_position >= PW'(tskl_pkg::SCAN_LAG) && !match_seen) begin
        if (start_ext < SW'(scan_limit) &&
            CMPW'(byte_position) < CMPW'(declared_length) && keyword_hit) begin
          match_seen_next   = 1'b1;
          match_offset_next = start_ext[tskl_pkg::OFFSET_WIDTH-1:0];
        end
      end
    end
  end

  always_comb begin
    qlen = declared_length_next - tskl_pkg::LENGTH_WIDTH'(tskl_pkg::HEADER_BYTES)
           - tskl_pkg::LENGTH_WIDTH'(match_offset_next);
    result.status       = tskl_pkg::ST_FOUND;
    result.query_offset = '0;
    result.query_length = '0;
    if (byte_position_next < PW'(tskl_pkg::HEADER_BYTES)) begin
      result.status = tskl_pkg::ST_SHORT;
    end else if (type_byte_next != tskl_pkg::SQL_BATCH_TYPE) begin
      result.status = tskl_pkg::ST_NOT_BATCH;
    end else if (declared_length_next <
                 tskl_pkg::LENGTH_WIDTH'(tskl_pkg::HEADER_BYTES) ||
                 CMPW'(declared_length_next) > CMPW'(byte_position_next)) begin
      result.status = tskl_pkg::ST_BAD_LENGTH;
    end else if (!match_seen_next) begin
      result.status = tskl_pkg::ST_NO_KEYWORD;
    end else begin
      result.query_offset = match_offset_next;
      result.query_length = (qlen > query_cap) ? query_cap : qlen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= tskl_pkg::SCAN_LIMIT_RESET;
      query_cap  <= tskl_pkg::QUERY_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tskl_pkg::REG_SCAN_LIMIT: scan_limit <= cfg_data[tskl_pkg::SCAN_LIMIT_WIDTH-1:0];
        tskl_pkg::REG_QUERY_CAP:  query_cap  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      byte_window     <= '0;
      type_byte       <= '0;
      declared_length <= '0;
      match_seen      <= 1'b0;
      match_offset    <= '0;
    end else if (in_fire) begin
      if (s_tlast) begin
        byte_position   <= '0;
        byte_window     <= '0;
        type_byte       <= '0;
        declared_length <= '0;
        match_seen      <= 1'b0;
        match_offset    <= '0;
      end else begin
        byte_position   <= byte_position_next;
        byte_window     <= byte_window_next;
        type_byte       <= type_byte_next;
        declared_length <= declared_length_next;
        match_seen      <= match_seen_next;
        match_offset    <= match_offset_next;
      end
    end
  end

  // A new result can arrive only while the skid entry is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
        out_data  <= result;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data};

endmodule
